### rtl/tag_pkg.sv
// Package for the threshold automaton generation block.
// Holds field widths, register reset values and the register index codes.
// No dependencies.
`default_nettype none

package tag_pkg;

	localparam int DEF_MAX_ROW_WIDTH = 1024;
	localparam int DEF_VALUE_BITS    = 16;

	localparam int THR_W   = 17;
	localparam int NN_W    = 3;
	localparam int MR_W    = 16;
	localparam int RW_W    = 11;
	localparam int DIST_W  = 16;
	localparam int COUNT_W = 21;
	localparam int SUM_W   = 36;
	localparam int CFG_W   = 17;
	localparam int IDX_W   = 3;

	localparam logic [THR_W-1:0] THR_RESET = 17'd32768;
	localparam logic [NN_W-1:0]  NN_RESET  = 3'd2;
	localparam logic [MR_W-1:0]  MR_RESET  = 16'd0;
	localparam logic [RW_W-1:0]  RW_RESET  = 11'd1024;

	typedef enum logic [IDX_W-1:0] {
		CFG_THRESHOLD  = 3'd0,
		CFG_NEIGHBOURS = 3'd1,
		CFG_MEAN_RANGE = 3'd2,
		CFG_ROW_WIDTH  = 3'd3
	} cfg_index_t;

endpackage

`default_nettype wire

### rtl/threshold_automaton_generation.sv
// Top level of the threshold automaton generation block: line buffers, survival logic, totals.
// Depends on tag_pkg for widths, register defaults and register index codes.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------------------
//   in      | to block  | in_valid / in_stall   | cell_value, cell_enabled, cell_alive,
//           |           |                      | center_distance, padding
//   out     | from block| out_valid / out_stall | alive_next, final_cell, outer_count,
//           |           |                      | inner_count, inner_value_sum
//   cfg     | to block  | cfg_valid / cfg_ready | cfg_index, cfg_data (cfg_ready always high)
//
// One cell per cycle sustained while the output is not held; a result leaves through the line
// buffer read stage, then the output register, after its cell is taken.
// The row buffer is written when a cell is taken; the qualify buffer is written when the
// cell moves out of the read stage, with forwarding for a one-cell row.
// Reset clears position, valid flags, totals and config registers; line buffers and data registers are not cleared.
// in_stall rises only while the read stage is full and the output register is held.
`default_nettype none

module threshold_automaton_generation
	import tag_pkg::*;
#(
	parameter int MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH,
	parameter int VALUE_BITS    = DEF_VALUE_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [VALUE_BITS-1:0] cell_value,
	input  wire logic                  cell_enabled,
	input  wire logic                  cell_alive,
	input  wire logic [DIST_W-1:0]     center_distance,
	input  wire logic                  padding,

	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       alive_next,
	output logic                       final_cell,
	output logic [COUNT_W-1:0]         outer_count,
	output logic [COUNT_W-1:0]         inner_count,
	output logic [SUM_W-1:0]           inner_value_sum,

	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [IDX_W-1:0]      cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data
);

	localparam int CW    = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
	localparam int WB    = (CW + 1 > RW_W) ? CW + 1 : RW_W;
	localparam int TW    = (VALUE_BITS > THR_W) ? VALUE_BITS : THR_W;
	localparam int ME_W  = VALUE_BITS + 2;
	localparam int QBIT  = VALUE_BITS;
	localparam int OBIT  = VALUE_BITS + 1;
	localparam logic [WB-1:0] WMAX = WB'(MAX_ROW_WIDTH);
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

	// configuration registers
	logic [THR_W-1:0] thr_q;
	logic [NN_W-1:0]  nn_q;
	logic [MR_W-1:0]  mr_q;
	logic [RW_W-1:0]  rw_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			nn_q  <= NN_RESET;
			mr_q  <= MR_RESET;
			rw_q  <= RW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_THRESHOLD:  thr_q <= cfg_data[THR_W-1:0];
				CFG_NEIGHBOURS: nn_q  <= cfg_data[NN_W-1:0];
				CFG_MEAN_RANGE: mr_q  <= cfg_data[MR_W-1:0];
				CFG_ROW_WIDTH:  rw_q  <= cfg_data[RW_W-1:0];
				default: ;
			endcase
		end
	end

	// position tracking
	logic [CW-1:0] col_q;
	logic [1:0]    row_q;   // 0, 1, or 2 meaning two or more

	logic [WB-1:0] weff, colx, col_eff, col_inc;
	logic [CW-1:0] col_a, col_a_inc;
	logic          last_col, ignore, acc, qual, outer;

	always_comb begin
		weff = WB'(rw_q);
		if (weff == '0) begin
			weff = WB'(1);
		end else if (weff > WMAX) begin
			weff = WMAX;
		end
		colx    = WB'(col_q);
		col_eff = (colx >= weff) ? weff - WB'(1) : colx;
		col_inc = col_eff + WB'(1);
		last_col  = (col_inc >= weff);
		col_a     = col_eff[CW-1:0];
		col_a_inc = col_inc[CW-1:0];
	end

	assign ignore = (row_q == 2'd0) && padding;
	assign qual   = !padding && cell_enabled && cell_alive && (TW'(cell_value) < TW'(thr_q));
	assign outer  = center_distance > mr_q;

	// read stage
	logic                s1_v_q;
	logic                up_ok_s1, left_ok_s1, right_ok_s1, final_s1, qual_s1;
	logic                fwd_s1, fwd_val_s1;
	logic [CW-1:0]       col_s1;
	logic [ME_W-1:0]     mid_c_s1, mid_r_s1;
	logic                up_s1;
	logic                out_free, s1_adv, s1_load;

	assign out_free = !out_valid || !out_stall;
	assign s1_adv   = s1_v_q && out_free;
	assign in_stall = s1_v_q && !out_free;
	assign acc      = in_valid && !in_stall;
	assign s1_load  = acc && (row_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= 2'd0;
		end else if (acc && !ignore) begin
			if (last_col) begin
				col_q <= '0;
				if (padding) begin
					row_q <= 2'd0;
				end else if (row_q != 2'd2) begin
					row_q <= row_q + 2'd1;
				end
			end else begin
				col_q <= col_a_inc;
			end
		end
	end

	// middle row buffer: written as a cell is taken, read before that write
	logic [ME_W-1:0] mid_mem [MAX_ROW_WIDTH];

	always_ff @(posedge clk) begin
		if (acc && !ignore) begin
			mid_mem[col_a] <= {outer, qual, cell_value};
		end
		if (s1_load) begin
			mid_c_s1 <= mid_mem[col_a];
			mid_r_s1 <= mid_mem[col_a_inc];
		end
	end

	// upper row qualify buffer: written as a cell leaves the read stage
	logic up_mem [MAX_ROW_WIDTH];
	logic mq, upq, surv;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			up_mem[col_s1] <= mq;
		end
		if (s1_load) begin
			up_s1 <= up_mem[col_a];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			col_s1      <= col_a;
			up_ok_s1    <= (row_q == 2'd2);
			left_ok_s1  <= (col_eff != '0);
			right_ok_s1 <= !last_col;
			final_s1    <= last_col && padding;
			qual_s1     <= qual;
			// same-edge write to the entry being read: take the written bit
			fwd_s1      <= s1_adv && (col_s1 == col_a);
			fwd_val_s1  <= mq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (s1_load) begin
			s1_v_q <= 1'b1;
		end else if (s1_adv) begin
			s1_v_q <= 1'b0;
		end
	end

	// survival and totals
	logic                 left_q;
	logic [COUNT_W-1:0]   outer_q, inner_q;
	logic [SUM_W-1:0]     sum_q;
	logic [COUNT_W-1:0]   outer_nx, inner_nx;
	logic [SUM_W-1:0]     sum_nx;
	logic [SUM_W:0]       sum_ext;
	logic [NN_W-1:0]      cnt;

	assign mq  = mid_c_s1[QBIT];
	assign upq = fwd_s1 ? fwd_val_s1 : up_s1;

	always_comb begin
		cnt = NN_W'(up_ok_s1 & upq) + NN_W'(left_ok_s1 & left_q) + NN_W'(qual_s1)
			+ NN_W'(right_ok_s1 & mid_r_s1[QBIT]);
		surv     = mq && (cnt >= nn_q);
		outer_nx = outer_q;
		inner_nx = inner_q;
		sum_nx   = sum_q;
		sum_ext  = {1'b0, sum_q} + (SUM_W + 1)'(mid_c_s1[VALUE_BITS-1:0]);
		if (surv) begin
			if (mid_c_s1[OBIT]) begin
				if (outer_q != COUNT_MAX) outer_nx = outer_q + COUNT_W'(1);
			end else begin
				if (inner_q != COUNT_MAX) inner_nx = inner_q + COUNT_W'(1);
				sum_nx = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= 1'b0;
			outer_q <= '0;
			inner_q <= '0;
			sum_q   <= '0;
		end else if (s1_adv) begin
			left_q <= mq;
			if (final_s1) begin
				outer_q <= '0;
				inner_q <= '0;
				sum_q   <= '0;
			end else begin
				outer_q <= outer_nx;
				inner_q <= inner_nx;
				sum_q   <= sum_nx;
			end
		end
	end

	// output register
	logic out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_adv) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			alive_next      <= surv;
			final_cell      <= final_s1;
			outer_count     <= final_s1 ? outer_nx : '0;
			inner_count     <= final_s1 ? inner_nx : '0;
			inner_value_sum <= final_s1 ? sum_nx : '0;
		end
	end

	assign out_valid = out_v_q;

	// checks
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_v_q && out_v_q))
		else $error("input stalled with free read stage");

	a_totals_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !final_cell) |->
			(outer_count == '0 && inner_count == '0 && inner_value_sum == '0))
		else $error("totals shown on a non-final result");

	a_totals_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && final_s1) |=> (outer_q == '0 && inner_q == '0 && sum_q == '0))
		else $error("totals not cleared after final cell");

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (WB'(col_q) < weff))
		else $error("column position outside the row");

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking bench for threshold_automaton_generation: raster cells in, new states out.
// Keeps its own line buffers and totals to predict every new state and the totals.
// Depends on tag_pkg and the RTL top level only.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tag_pkg::*;

	localparam int unsigned ROW_CAP       = 1024;
	localparam int unsigned RANDOM_CELLS  = 450;
	localparam int unsigned COLUMN_ROWS   = 60;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned LONG_HOLD     = 300;
	localparam int          SENDER        = 0;
	localparam int          RECEIVER      = 1;
	localparam logic [IDX_W-1:0] CFG_UNUSED = 3'd7;

	typedef struct packed {
		logic [DEF_VALUE_BITS-1:0] value;
		logic                      enabled;
		logic                      alive;
		logic [DIST_W-1:0]         distance;
		logic                      padding;
	} cell_t;

	typedef struct packed {
		logic                      alive_next;
		logic                      final_cell;
		logic [COUNT_W-1:0]        outer_count;
		logic [COUNT_W-1:0]        inner_count;
		logic [SUM_W-1:0]          inner_value_sum;
	} new_state_t;

	typedef struct packed {
		logic [DEF_VALUE_BITS-1:0] value;
		logic                      qual;
		logic                      outer;
	} row_cell_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [DEF_VALUE_BITS-1:0] cell_value = '0;
	logic                      cell_enabled = 1'b0;
	logic                      cell_alive = 1'b0;
	logic [DIST_W-1:0]         center_distance = '0;
	logic                      padding = 1'b0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic                      alive_next;
	logic                      final_cell;
	logic [COUNT_W-1:0]        outer_count;
	logic [COUNT_W-1:0]        inner_count;
	logic [SUM_W-1:0]          inner_value_sum;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [IDX_W-1:0]          cfg_index = '0;
	logic [CFG_W-1:0]          cfg_data = '0;

	threshold_automaton_generation uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cell_value(cell_value), .cell_enabled(cell_enabled), .cell_alive(cell_alive),
		.center_distance(center_distance), .padding(padding),
		.out_valid(out_valid), .out_stall(out_stall),
		.alive_next(alive_next), .final_cell(final_cell), .outer_count(outer_count),
		.inner_count(inner_count), .inner_value_sum(inner_value_sum),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	initial begin
		#10_000_000;
		$display("FAIL threshold_automaton_generation");
		$finish;
	end

	// automaton rules and state as the block should hold them
	logic [THR_W-1:0]   rule_threshold = THR_RESET;
	logic [NN_W-1:0]    rule_needed    = NN_RESET;
	logic [MR_W-1:0]    rule_range     = MR_RESET;
	logic [RW_W-1:0]    rule_width     = RW_RESET;
	bit                 up_qual [DEF_MAX_ROW_WIDTH];
	row_cell_t          mid_row [DEF_MAX_ROW_WIDTH];
	bit                 left_qual = 1'b0;
	int unsigned        col_pos = 0;
	int unsigned        row_pos = 0;
	logic [COUNT_W-1:0] outer_tot = '0;
	logic [COUNT_W-1:0] inner_tot = '0;
	logic [SUM_W-1:0]   inner_sum = '0;

	cell_t       cell_backlog [$];
	new_state_t  due_states [$];
	cell_t       offered;
	int unsigned cells_sent = 0;
	int unsigned cells_taken = 0;
	int unsigned results_seen = 0;
	int unsigned results_ack = 0;
	int unsigned send_gap = 0;
	int unsigned sink_wait = 0;
	int unsigned calm_left [2] = '{0, 0};
	int unsigned errors = 0;

	function automatic int unsigned eff_width();
		if (rule_width == 0)
			return 1;
		if (rule_width > DEF_MAX_ROW_WIDTH)
			return DEF_MAX_ROW_WIDTH;
		return 32'(rule_width);
	endfunction

	function automatic int unsigned draw_idle(int side);
		if (calm_left[side] != 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm_left[side] = $urandom_range(20, 80);
			return 0;
		end
		return $urandom_range(0, 13);
	endfunction

	// advance the automaton by one cell; queue the new state of the cell above, if any
	function automatic void judge_cell(cell_t c);
		int unsigned w;
		int unsigned col;
		int unsigned cnt;
		bit qual;
		bit outer;
		bit surv;
		bit emitted;
		row_cell_t above;
		new_state_t st;
		logic [SUM_W:0] widened;
		w = eff_width();
		col = (col_pos >= w) ? w - 1 : col_pos;
		if (row_pos == 0 && c.padding)
			return;
		qual = !c.padding && c.enabled && c.alive && (c.value < rule_threshold);
		outer = c.distance > rule_range;
		emitted = 1'b0;
		st = '0;
		if (row_pos > 0) begin
			above = mid_row[col];
			cnt = 0;
			if (row_pos >= 2)
				cnt += up_qual[col];
			if (col > 0)
				cnt += left_qual;
			if (qual)
				cnt++;
			if (col + 1 < w && mid_row[col + 1].qual)
				cnt++;
			surv = above.qual && (cnt >= rule_needed);
			if (surv && above.outer) begin
				if (outer_tot != '1)
					outer_tot++;
			end else if (surv) begin
				if (inner_tot != '1)
					inner_tot++;
				widened = {1'b0, inner_sum} + (SUM_W + 1)'(above.value);
				inner_sum = widened[SUM_W] ? '1 : widened[SUM_W-1:0];
			end
			left_qual = above.qual;
			up_qual[col] = above.qual;
			st.alive_next = surv;
			emitted = 1'b1;
		end
		mid_row[col] = '{value: c.value, qual: qual, outer: outer};
		if (col + 1 >= w) begin
			col_pos = 0;
			if (c.padding) begin
				// end of generation: report and clear the totals
				if (emitted) begin
					st.final_cell = 1'b1;
					st.outer_count = outer_tot;
					st.inner_count = inner_tot;
					st.inner_value_sum = inner_sum;
				end
				outer_tot = '0;
				inner_tot = '0;
				inner_sum = '0;
				row_pos = 0;
			end else if (row_pos < ROW_CAP) begin
				row_pos++;
			end
		end else begin
			col_pos = col + 1;
		end
		if (emitted)
			due_states.push_back(st);
	endfunction

	always @(negedge clk) begin : cell_driver
		if (!in_valid || cells_taken == cells_sent) begin
			if (send_gap != 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (cell_backlog.size() != 0) begin
				offered = cell_backlog.pop_front();
				cell_value <= offered.value;
				cell_enabled <= offered.enabled;
				cell_alive <= offered.alive;
				center_distance <= offered.distance;
				padding <= offered.padding;
				in_valid <= 1'b1;
				cells_sent++;
				send_gap <= draw_idle(SENDER);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : result_sink
		if (results_ack != results_seen) begin
			results_ack = results_seen;
			// now and then hold off long enough to back the block up
			sink_wait = (results_seen % 150 == 100) ? LONG_HOLD : draw_idle(RECEIVER);
		end
		out_stall <= (sink_wait != 0);
		if (sink_wait != 0)
			sink_wait--;
	end

	always @(posedge clk) begin : transfer_monitor
		new_state_t want;
		if (arst_n && in_valid && !in_stall) begin
			judge_cell(offered);
			cells_taken++;
		end
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (due_states.size() == 0) begin
				$error("new state with none outstanding: alive_next %0d final_cell %0d",
					alive_next, final_cell);
				errors++;
			end else begin
				want = due_states.pop_front();
				if (alive_next !== want.alive_next) begin
					$error("alive_next: expected %0d, got %0d", want.alive_next, alive_next);
					errors++;
				end
				if (final_cell !== want.final_cell) begin
					$error("final_cell: expected %0d, got %0d", want.final_cell, final_cell);
					errors++;
				end
				if (outer_count !== want.outer_count) begin
					$error("outer_count: expected %0d, got %0d", want.outer_count, outer_count);
					errors++;
				end
				if (inner_count !== want.inner_count) begin
					$error("inner_count: expected %0d, got %0d", want.inner_count, inner_count);
					errors++;
				end
				if (inner_value_sum !== want.inner_value_sum) begin
					$error("inner_value_sum: expected %0d, got %0d",
						want.inner_value_sum, inner_value_sum);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_THRESHOLD:  rule_threshold = data[THR_W-1:0];
			CFG_NEIGHBOURS: rule_needed = data[NN_W-1:0];
			CFG_MEAN_RANGE: rule_range = data[MR_W-1:0];
			CFG_ROW_WIDTH:  rule_width = data[RW_W-1:0];
			default: ;
		endcase
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	task automatic set_rules(logic [CFG_W-1:0] thr, logic [CFG_W-1:0] needed,
			logic [CFG_W-1:0] range, logic [CFG_W-1:0] width);
		write_reg(CFG_THRESHOLD, thr);
		write_reg(CFG_NEIGHBOURS, needed);
		write_reg(CFG_MEAN_RANGE, range);
		write_reg(CFG_ROW_WIDTH, width);
	endtask

	// wait until every cell is taken and every new state is out, then let the pipe empty
	task automatic settle();
		int unsigned spins;
		while (cell_backlog.size() != 0 || cells_taken != cells_sent)
			@(posedge clk);
		spins = 0;
		while (due_states.size() != 0 && spins < 2000) begin
			@(posedge clk);
			spins++;
		end
		if (due_states.size() != 0) begin
			$error("%0d new states never came out", due_states.size());
			errors++;
			due_states.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// flush with padding rows until the generation is over, so the width may change
	task automatic close_generation();
		while (row_pos != 0) begin
			repeat (eff_width()) cell_backlog.push_back(rand_cell(1'b1));
			settle();
		end
	endtask

	function automatic cell_t make_cell(int unsigned value, bit en, bit al, int unsigned cdist,
			bit pad);
		cell_t c;
		c.value = DEF_VALUE_BITS'(value);
		c.enabled = en;
		c.alive = al;
		c.distance = DIST_W'(cdist);
		c.padding = pad;
		return c;
	endfunction

	function automatic cell_t rand_cell(bit pad);
		int unsigned value;
		value = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 1023);
		return make_cell(value, $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0,
			$urandom_range(0, 65535), pad);
	endfunction

	initial begin : stimulus
		int unsigned random_cells;
		int unsigned w;
		int unsigned rows;
		int unsigned thr;
		int unsigned needed;
		int unsigned range;
		bit noisy;

		@(posedge arst_n);

		// width past the maximum acts as the maximum; one full row, then a narrow flush row
		write_reg(CFG_ROW_WIDTH, CFG_W'(2047));
		repeat (DEF_MAX_ROW_WIDTH) cell_backlog.push_back(rand_cell(1'b0));
		settle();
		write_reg(CFG_ROW_WIDTH, CFG_W'(8));
		close_generation();

		// zero width acts as one; widest threshold; padding in the first row is dropped
		set_rules(17'd65536, 17'd0, 17'd0, 17'd0);
		write_reg(CFG_UNUSED, CFG_W'($urandom_range(0, 131071)));
		cell_backlog.push_back(make_cell(65535, 1'b1, 1'b1, 0, 1'b1));
		cell_backlog.push_back(make_cell(65535, 1'b1, 1'b1, 0, 1'b0));
		cell_backlog.push_back(make_cell(0, 1'b1, 1'b1, 65535, 1'b0));
		cell_backlog.push_back(make_cell(0, 1'b1, 1'b1, 0, 1'b1));
		settle();

		// all four neighbours needed; center of a 3x3 block survives with the largest value under the threshold
		set_rules(17'd65535, 17'd4, 17'd65535, 17'd3);
		cell_backlog.push_back(make_cell(100, 1'b1, 1'b1, $urandom_range(0, 65535), 1'b0));
		cell_backlog.push_back(make_cell(65534, 1'b1, 1'b1, $urandom_range(0, 65535), 1'b0));
		cell_backlog.push_back(make_cell(65535, 1'b1, 1'b1, $urandom_range(0, 65535), 1'b0));
		cell_backlog.push_back(make_cell(7, 1'b1, 1'b1, 65535, 1'b0));
		cell_backlog.push_back(make_cell(65534, 1'b1, 1'b1, 65535, 1'b0));
		cell_backlog.push_back(make_cell(9, 1'b1, 1'b1, 0, 1'b0));
		cell_backlog.push_back(make_cell(1, 1'b0, 1'b1, 0, 1'b0));
		cell_backlog.push_back(make_cell(2, 1'b1, 1'b1, 0, 1'b0));
		cell_backlog.push_back(make_cell(3, 1'b1, 1'b0, 0, 1'b0));
		repeat (3) cell_backlog.push_back(rand_cell(1'b1));
		settle();

		// shrink the width in the middle of the first row
		set_rules(17'd32768, 17'd1, 17'd100, 17'd4);
		cell_backlog.push_back(make_cell(10, 1'b1, 1'b1, 50, 1'b0));
		cell_backlog.push_back(make_cell(20, 1'b1, 1'b1, 200, 1'b0));
		settle();
		write_reg(CFG_ROW_WIDTH, CFG_W'(2));
		cell_backlog.push_back(make_cell(30, 1'b1, 1'b1, 100, 1'b0));
		cell_backlog.push_back(make_cell(40, 1'b1, 1'b1, 101, 1'b0));
		cell_backlog.push_back(make_cell(50, 1'b1, 1'b1, 0, 1'b0));
		repeat (2) cell_backlog.push_back(rand_cell(1'b1));
		settle();

		random_cells = 0;
		while (random_cells < RANDOM_CELLS) begin
			case ($urandom_range(0, 5))
				0: thr = 0;
				1: thr = 65536;
				2: thr = 131071;
				default: thr = $urandom_range(0, 65536);
			endcase
			needed = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
			case ($urandom_range(0, 3))
				0: range = 0;
				1: range = 65535;
				default: range = $urandom_range(0, 65535);
			endcase
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
			set_rules(CFG_W'(thr), CFG_W'(needed), CFG_W'(range), CFG_W'(w));
			w = eff_width();
			noisy = ($urandom_range(0, 5) == 0);
			repeat ($urandom_range(1, 3)) begin
				rows = $urandom_range(1, 6);
				for (int r = 0; r <= rows; r++) begin
					repeat (w) begin
						// drop padding anywhere in noisy phases
						cell_backlog.push_back(rand_cell(noisy ? ($urandom_range(0, 4) == 0)
							: (r == rows)));
						random_cells++;
					end
				end
			end
			settle();
			close_generation();
		end

		// one-cell rows, more of them than the row counter can hold
		set_rules(CFG_W'($urandom_range(0, 65536)), CFG_W'($urandom_range(0, 2)),
			CFG_W'($urandom_range(0, 65535)), CFG_W'(1));
		repeat (COLUMN_ROWS) cell_backlog.push_back(rand_cell(1'b0));
		cell_backlog.push_back(rand_cell(1'b1));
		settle();
		close_generation();

		if (errors == 0)
			$display("PASS threshold_automaton_generation");
		else
			$display("FAIL threshold_automaton_generation");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
rtl/tag_pkg.sv
rtl/threshold_automaton_generation.sv
test/testbench.sv
